// ===== hdl/dpb_pkg.sv =====
// ----------------------------------------------------------------------------
// dpb_pkg
// Shared types and constants for the depth pixel back-projection block.
// ----------------------------------------------------------------------------
package dpb_pkg;

  // Image bounds; pixels at or beyond them are dropped
  localparam int unsigned MAX_COLS = 1024;
  localparam int unsigned MAX_ROWS = 1024;

  // Field widths
  localparam int unsigned PIX_W   = 10;
  localparam int unsigned DEPTH_W = 16;
  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned COLOR_W = 3 * CHAN_W;
  localparam int unsigned COORD_W = 24;
  localparam int unsigned COEF_W  = 32;

  // Bounds compare width, wide enough for the largest image size
  localparam int unsigned BOUND_W = 13;

  // Valid depth window in millimeters
  localparam logic [DEPTH_W-1:0] DEPTH_MIN_MM = 16'd400;
  localparam logic [DEPTH_W-1:0] DEPTH_MAX_MM = 16'd6000;

  // Register reset values, signed Q8.24
  localparam logic [COEF_W-1:0] COEF_ONE  = 32'h0100_0000;
  localparam logic [COEF_W-1:0] COEF_ZERO = 32'h0000_0000;

  // APB address bits and register map
  localparam int unsigned ADDR_W = 5;

  typedef enum logic [2:0] {
    REG_X_PER_COL = 3'd0,
    REG_X_PER_ROW = 3'd1,
    REG_X_OFFSET  = 3'd2,
    REG_Y_PER_COL = 3'd3,
    REG_Y_PER_ROW = 3'd4,
    REG_Y_OFFSET  = 3'd5
  } reg_idx_e;

  // One row of the inverse intrinsic matrix
  typedef struct packed {
    logic signed [COEF_W-1:0] per_col;
    logic signed [COEF_W-1:0] per_row;
    logic signed [COEF_W-1:0] offset;
  } ray_coef_t;

endpackage

// ===== hdl/dpb_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// dpb_cfg_regs
// APB register file holding the two inverse intrinsic rows.
// ----------------------------------------------------------------------------
module dpb_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dpb_pkg::ADDR_W-1:0]    paddr,
  input  logic [dpb_pkg::COEF_W-1:0]    pwdata,
  output logic [dpb_pkg::COEF_W-1:0]    prdata,
  output logic                          pready,
  output dpb_pkg::ray_coef_t            coef_x_o,
  output dpb_pkg::ray_coef_t            coef_y_o
);

  dpb_pkg::ray_coef_t coef_x_q, coef_y_q;
  logic [2:0]         reg_idx;
  logic               wr_en;

  assign reg_idx = paddr[4:2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  // Write one coefficient word; unknown addresses are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_x_q.per_col <= dpb_pkg::COEF_ONE;
      coef_x_q.per_row <= dpb_pkg::COEF_ZERO;
      coef_x_q.offset  <= dpb_pkg::COEF_ZERO;
      coef_y_q.per_col <= dpb_pkg::COEF_ZERO;
      coef_y_q.per_row <= dpb_pkg::COEF_ONE;
      coef_y_q.offset  <= dpb_pkg::COEF_ZERO;
    end else if (wr_en) begin
      case (reg_idx)
        dpb_pkg::REG_X_PER_COL: coef_x_q.per_col <= pwdata;
        dpb_pkg::REG_X_PER_ROW: coef_x_q.per_row <= pwdata;
        dpb_pkg::REG_X_OFFSET:  coef_x_q.offset  <= pwdata;
        dpb_pkg::REG_Y_PER_COL: coef_y_q.per_col <= pwdata;
        dpb_pkg::REG_Y_PER_ROW: coef_y_q.per_row <= pwdata;
        dpb_pkg::REG_Y_OFFSET:  coef_y_q.offset  <= pwdata;
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (reg_idx)
      dpb_pkg::REG_X_PER_COL: prdata = coef_x_q.per_col;
      dpb_pkg::REG_X_PER_ROW: prdata = coef_x_q.per_row;
      dpb_pkg::REG_X_OFFSET:  prdata = coef_x_q.offset;
      dpb_pkg::REG_Y_PER_COL: prdata = coef_y_q.per_col;
      dpb_pkg::REG_Y_PER_ROW: prdata = coef_y_q.per_row;
      dpb_pkg::REG_Y_OFFSET:  prdata = coef_y_q.offset;
      default:                prdata = '0;
    endcase
  end

  assign coef_x_o = coef_x_q;
  assign coef_y_o = coef_y_q;

endmodule

// ===== hdl/dpb_axis_scale.sv =====
// ----------------------------------------------------------------------------
// dpb_axis_scale
// Five-stage datapath for one camera axis: ray = a*u + b*v + c (Q8.24 coefficients, Q20.24 ray),
// scaled by depth, rounded to millimeters, negated and saturated to 24 bits.
// ----------------------------------------------------------------------------
module dpb_axis_scale (
  input  logic                                clk_i,
  input  logic [dpb_pkg::PIX_W-1:0]           col_i,
  input  logic [dpb_pkg::PIX_W-1:0]           row_i,
  input  logic [dpb_pkg::DEPTH_W-1:0]         depth_i,
  input  dpb_pkg::ray_coef_t                  coef_i,
  output logic signed [dpb_pkg::COORD_W-1:0]  coord_o
);

  localparam int unsigned PROD_W = dpb_pkg::COEF_W + dpb_pkg::PIX_W;   // 42
  localparam int unsigned RAY_W  = PROD_W + 2;                          // 44
  localparam int unsigned FRAC_W = 24;
  localparam int unsigned HI_W   = RAY_W - FRAC_W;                      // 20
  localparam int unsigned MLO_W  = dpb_pkg::DEPTH_W + FRAC_W;           // 40
  localparam int unsigned MHI_W  = HI_W + dpb_pkg::DEPTH_W;             // 36
  localparam int unsigned CAM_W  = MHI_W + 1;                           // 37
  localparam int unsigned NEG_W  = CAM_W + 1;                           // 38

  // Stage 1: column and row products
  logic signed [PROD_W-1:0]          pu_d, pu_q, pv_d, pv_q;
  logic [dpb_pkg::DEPTH_W-1:0]       depth1_q, depth2_q;
  // Stage 2: ray
  logic signed [RAY_W-1:0]           ray_d, ray_q;
  // Stage 3: split depth product
  logic [MLO_W-1:0]                  mlo_d, mlo_q;
  logic signed [MHI_W-1:0]           mhi_d, mhi_q;
  // Stage 4: camera coordinate
  logic [MLO_W:0]                    rnd_sum;
  logic signed [CAM_W-1:0]           cam_d, cam_q;
  // Stage 5: negate and saturate
  logic signed [NEG_W-1:0]           neg;
  logic signed [dpb_pkg::COORD_W-1:0] coord_d, coord_q;

  assign pu_d = coef_i.per_col * $signed({1'b0, col_i});
  assign pv_d = coef_i.per_row * $signed({1'b0, row_i});

  assign ray_d = pu_q + pv_q + coef_i.offset;

  // Depth times ray, as depth*low24 plus depth*high part
  assign mlo_d = MLO_W'(depth2_q) * MLO_W'(ray_q[FRAC_W-1:0]);
  assign mhi_d = $signed(ray_q[RAY_W-1:FRAC_W]) * $signed({1'b0, depth2_q});

  // Round to nearest, ties up, then drop the fraction
  assign rnd_sum = {1'b0, mlo_q} + (MLO_W+1)'(1 << (FRAC_W - 1));
  assign cam_d   = mhi_q + $signed({1'b0, rnd_sum[MLO_W:FRAC_W]});

  // Negate into the vehicle frame and clamp to 24 bits
  assign neg = -(NEG_W'(cam_q));
  always_comb begin
    if (&neg[NEG_W-1:dpb_pkg::COORD_W-1] || ~|neg[NEG_W-1:dpb_pkg::COORD_W-1]) begin
      coord_d = neg[dpb_pkg::COORD_W-1:0];
    end else if (neg[NEG_W-1]) begin
      coord_d = {1'b1, {(dpb_pkg::COORD_W-1){1'b0}}};
    end else begin
      coord_d = {1'b0, {(dpb_pkg::COORD_W-1){1'b1}}};
    end
  end

  // Advance every stage each cycle; valid bits travel alongside in the top
  always_ff @(posedge clk_i) begin
    pu_q     <= pu_d;
    pv_q     <= pv_d;
    depth1_q <= depth_i;
    ray_q    <= ray_d;
    depth2_q <= depth1_q;
    mlo_q    <= mlo_d;
    mhi_q    <= mhi_d;
    cam_q    <= cam_d;
    coord_q  <= coord_d;
  end

  assign coord_o = coord_q;

endmodule

// ===== hdl/depth_pixel_backprojection.sv =====
// ----------------------------------------------------------------------------
// depth_pixel_backprojection
// An accepted start reaches the result_valid_o strobe through the valid shift register, in step with the datapath.
// Throughput: one pixel per cycle; busy stays low, the five-stage multiply
// pipeline accepts a new word every clock and the receiver cannot stall it.
// Pixels with depth outside 400..6000 mm or outside the image give no result.
// Reset clears the pipeline valid bits and loads identity ray coefficients.
// ----------------------------------------------------------------------------
module depth_pixel_backprojection #(
  parameter int unsigned MAX_COLS = dpb_pkg::MAX_COLS,
  parameter int unsigned MAX_ROWS = dpb_pkg::MAX_ROWS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Pixel word
  input  logic                                start,
  output logic                                busy,
  input  logic [dpb_pkg::PIX_W-1:0]           pixel_col_i,
  input  logic [dpb_pkg::PIX_W-1:0]           pixel_row_i,
  input  logic [dpb_pkg::DEPTH_W-1:0]         depth_raw_i,
  input  logic [dpb_pkg::CHAN_W-1:0]          blue_in_i,
  input  logic [dpb_pkg::CHAN_W-1:0]          green_in_i,
  input  logic [dpb_pkg::CHAN_W-1:0]          red_in_i,
  // Point word
  output logic                                result_valid_o,
  output logic [dpb_pkg::DEPTH_W-1:0]         point_forward_o,
  output logic signed [dpb_pkg::COORD_W-1:0]  point_left_o,
  output logic signed [dpb_pkg::COORD_W-1:0]  point_up_o,
  output logic [dpb_pkg::COLOR_W-1:0]         packed_colour_o,
  // APB configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [dpb_pkg::ADDR_W-1:0]          paddr,
  input  logic [dpb_pkg::COEF_W-1:0]          pwdata,
  output logic [dpb_pkg::COEF_W-1:0]          prdata,
  output logic                                pready
);

  localparam int unsigned STAGES = 5;

  dpb_pkg::ray_coef_t          coef_x, coef_y;
  logic                        accept, in_range;
  logic [STAGES-1:0]           valid_q, valid_d;
  logic [dpb_pkg::DEPTH_W-1:0] depth_q [STAGES];
  logic [dpb_pkg::COLOR_W-1:0] color_q [STAGES];

  // Configuration registers
  dpb_cfg_regs u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .coef_x_o (coef_x),
    .coef_y_o (coef_y)
  );

  // Accept every cycle; drop pixels outside the image or depth window
  assign busy     = 1'b0;
  assign accept   = start & ~busy;
  assign in_range = ({3'b000, pixel_col_i} < dpb_pkg::BOUND_W'(MAX_COLS))
                  & ({3'b000, pixel_row_i} < dpb_pkg::BOUND_W'(MAX_ROWS))
                  & (depth_raw_i >= dpb_pkg::DEPTH_MIN_MM)
                  & (depth_raw_i <= dpb_pkg::DEPTH_MAX_MM);

  // Advance the valid bits
  assign valid_d = {valid_q[STAGES-2:0], accept & in_range};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Carry depth and packed color alongside the datapath
  always_ff @(posedge clk_i) begin
    depth_q[0] <= depth_raw_i;
    color_q[0] <= {red_in_i, green_in_i, blue_in_i};
    for (int i = 1; i < STAGES; i++) begin
      depth_q[i] <= depth_q[i-1];
      color_q[i] <= color_q[i-1];
    end
  end

  // Vehicle left is minus camera x, vehicle up is minus camera y
  dpb_axis_scale u_left (
    .clk_i   (clk_i),
    .col_i   (pixel_col_i),
    .row_i   (pixel_row_i),
    .depth_i (depth_raw_i),
    .coef_i  (coef_x),
    .coord_o (point_left_o)
  );

  dpb_axis_scale u_up (
    .clk_i   (clk_i),
    .col_i   (pixel_col_i),
    .row_i   (pixel_row_i),
    .depth_i (depth_raw_i),
    .coef_i  (coef_y),
    .coord_o (point_up_o)
  );

  assign result_valid_o  = valid_q[STAGES-1];
  assign point_forward_o = depth_q[STAGES-1];
  assign packed_colour_o = color_q[STAGES-1];

endmodule
